### hdl/assert_macros.svh
// assertion helpers for the bounding box block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: never");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`else
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/mbbn_pkg.sv
// ----------------------------------------------------------------------------
// mbbn_pkg
// shared types, constants and single precision helper functions
// ----------------------------------------------------------------------------
package mbbn_pkg;

    localparam int TRI_W = 288;
    localparam int RES_W = 320;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;

    typedef logic [31:0] t_f32;

    typedef struct packed {
        t_f32 hi_z;
        t_f32 hi_y;
        t_f32 hi_x;
        t_f32 lo_z;
        t_f32 lo_y;
        t_f32 lo_x;
    } t_box;

    function automatic logic f_is_nan(input t_f32 x);
        return (x[30:23] == EXP_MAX) && (x[22:0] != 23'd0);
    endfunction

    // ieee a < b, false when either is nan
    function automatic logic f_lt(input t_f32 a, input t_f32 b);
        logic r;
        if (f_is_nan(a) || f_is_nan(b)) begin
            r = 1'b0;
        end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
            r = 1'b0;
        end else if (a[31] != b[31]) begin
            r = a[31];
        end else if (!a[31]) begin
            r = a[30:0] < b[30:0];
        end else begin
            r = a[30:0] > b[30:0];
        end
        return r;
    endfunction

    // exact halving, round to nearest even when the result is subnormal
    function automatic t_f32 f_half(input t_f32 x);
        logic [23:0] m;
        logic [23:0] r;
        t_f32        y;
        m = {(x[30:23] != 8'd0), x[22:0]};
        r = {1'b0, m[23:1]} + {23'd0, (m[0] & m[1])};
        if (x[30:23] == EXP_MAX) begin
            y = x;
        end else if (x[30:23] > 8'd1) begin
            y = {x[31], x[30:23] - 8'd1, x[22:0]};
        end else begin
            y = {x[31], 7'd0, r};
        end
        return y;
    endfunction

    // n holds hidden bit at 26, fraction, guard, round, sticky; e is biased, at least 1
    function automatic t_f32 f_round(input logic s, input logic [9:0] e,
                                     input logic [26:0] n);
        logic [7:0]  ef;
        logic        up;
        logic [30:0] mag;
        t_f32        y;
        ef  = n[26] ? e[7:0] : 8'd0;
        up  = n[2] & (n[1] | n[0] | n[3]);
        mag = {ef, n[25:3]} + {30'd0, up};
        if (e >= 10'd255) begin
            y = {s, EXP_MAX, 23'd0};
        end else begin
            y = {s, mag};
        end
        return y;
    endfunction

    function automatic logic [4:0] f_lzc27(input logic [26:0] v);
        logic [4:0] n;
        n = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) begin
                n = 5'(26 - i);
            end
        end
        return n;
    endfunction

    function automatic t_f32 f_canon(input t_f32 x);
        return f_is_nan(x) ? CANON_NAN : x;
    endfunction

endpackage

### hdl/mesh_bounding_box_normalizer.sv
// ----------------------------------------------------------------------------
// mesh_bounding_box_normalizer
// axis aligned bounding box of a triangle mesh with unit scale and centring
// ----------------------------------------------------------------------------
// throughput: one triangle per cycle while the box queue has room
// after the last triangle is taken, the box goes through six passes of the
//   shared four stage adder and the bit serial reciprocal (longest for a
//   subnormal extent) before tvalid rises
// the two entry box queue lets the next mesh stream in meanwhile
// reset: synchronous active low, clears running box and all handshakes
// ----------------------------------------------------------------------------
module mesh_bounding_box_normalizer
    import mbbn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // triangle input
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (32 bits each)
    input  logic [TRI_W-1:0] s_axis_tdata,
    // final_tri
    input  logic             s_axis_tlast,
    // box result
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, unit_scale, shift_x, shift_y, shift_z
    output logic [RES_W-1:0] m_axis_tdata
);

    // front to queue
    logic q_push;
    t_box q_box_in;
    logic q_full;
    // queue to back
    logic q_pop;
    logic q_valid;
    t_box q_box_out;

    // front folds each transaction into the running min and max
    mbbn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_push  (q_push),
        .o_box   (q_box_in),
        .i_full  (q_full)
    );

    // finished boxes wait here for the arithmetic
    mbbn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_box   (q_box_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_box   (q_box_out)
    );

    // back computes extents, scale and shifts and holds the result transaction
    mbbn_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_box   (q_box_out),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

endmodule

### hdl/mbbn_fifo.sv
// ----------------------------------------------------------------------------
// mbbn_fifo
// two entry queue of finished boxes between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbbn_fifo
    import mbbn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_box i_box,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_box o_box
);

    t_box       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_box   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_box;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full)
    `ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid)
    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt == 2'd3)
    `ASSERT_IMPLY(a_ptr_track, i_clk, i_rst_n, r_cnt != 2'd1, r_wp == r_rp)

endmodule

### hdl/mbbn_front.sv
// ----------------------------------------------------------------------------
// mbbn_front
// takes one triangle a cycle while the box queue is not full and folds it into the running box
// ----------------------------------------------------------------------------
module mbbn_front
    import mbbn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [TRI_W-1:0] i_data,
    input  logic             i_last,
    output logic             o_push,
    output t_box             o_box,
    input  logic             i_full
);

    t_f32 r_lo [3];
    t_f32 r_hi [3];
    logic r_first;
    t_f32 n_lo [3];
    t_f32 n_hi [3];
    logic acc;

    assign o_ready = !i_full;
    assign acc     = i_valid && o_ready;
    assign o_push  = acc && i_last;

    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            n_lo[ax] = r_first ? i_data[ax*32 +: 32] : r_lo[ax];
            n_hi[ax] = r_first ? i_data[ax*32 +: 32] : r_hi[ax];
            for (int v = 0; v < 3; v++) begin
                if (!f_lt(n_lo[ax], i_data[(3*v+ax)*32 +: 32])) begin
                    n_lo[ax] = i_data[(3*v+ax)*32 +: 32];
                end
                if (!f_lt(i_data[(3*v+ax)*32 +: 32], n_hi[ax])) begin
                    n_hi[ax] = i_data[(3*v+ax)*32 +: 32];
                end
            end
        end
    end

    assign o_box = '{hi_z: n_hi[2], hi_y: n_hi[1], hi_x: n_hi[0],
                     lo_z: n_lo[2], lo_y: n_lo[1], lo_x: n_lo[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            for (int ax = 0; ax < 3; ax++) begin
                r_lo[ax] <= '0;
                r_hi[ax] <= '0;
            end
        end else if (acc) begin
            r_first <= i_last;
            for (int ax = 0; ax < 3; ax++) begin
                r_lo[ax] <= n_lo[ax];
                r_hi[ax] <= n_hi[ax];
            end
        end
    end

endmodule

### hdl/mbbn_fadd.sv
// ----------------------------------------------------------------------------
// mbbn_fadd
// four stage single precision adder, round to nearest even
// ----------------------------------------------------------------------------
module mbbn_fadd
    import mbbn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_f32 i_a,
    input  t_f32 i_b,
    output logic o_done,
    output t_f32 o_res
);

    logic [3:0] r_vld;

    // stage 1 : specials, swap, align
    logic        big;
    t_f32        x;
    t_f32        y;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [7:0]  d;
    logic [4:0]  dd;
    logic [49:0] t;
    logic        spec;
    t_f32        specv;
    logic        a_inf;
    logic        b_inf;

    always_comb begin
        big   = (i_a[30:0] >= i_b[30:0]);
        x     = big ? i_a : i_b;
        y     = big ? i_b : i_a;
        ex    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey    = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d     = ex - ey;
        dd    = (d > 8'd26) ? 5'd26 : d[4:0];
        t     = {(y[30:23] != 8'd0), y[22:0], 26'd0} >> dd;
        a_inf = (i_a[30:23] == EXP_MAX) && (i_a[22:0] == 23'd0);
        b_inf = (i_b[30:23] == EXP_MAX) && (i_b[22:0] == 23'd0);
        spec  = 1'b1;
        if (f_is_nan(i_a) || f_is_nan(i_b) || (a_inf && b_inf && (i_a[31] != i_b[31]))) begin
            specv = CANON_NAN;
        end else if (a_inf) begin
            specv = i_a;
        end else if (b_inf) begin
            specv = i_b;
        end else begin
            specv = '0;
            spec  = 1'b0;
        end
    end

    logic        r1_spec;
    t_f32        r1_specv;
    logic        r1_s;
    logic        r1_sub;
    logic        r1_zs;
    logic [7:0]  r1_e;
    logic [26:0] r1_ma;
    logic [26:0] r1_mb;

    // stage 2 : add or subtract magnitudes
    logic        r2_spec;
    t_f32        r2_specv;
    logic        r2_s;
    logic        r2_zs;
    logic [7:0]  r2_e;
    logic [27:0] r2_sum;

    // stage 3 : normalise
    logic [4:0]  lz;
    logic [9:0]  em1;
    logic [4:0]  sh;
    logic [26:0] nn;
    logic [9:0]  ne;
    logic        ns;

    always_comb begin
        lz  = f_lzc27(r2_sum[26:0]);
        em1 = {2'd0, r2_e} - 10'd1;
        sh  = ({5'd0, lz} < em1) ? lz : em1[4:0];
        ns  = (r2_sum == 28'd0) ? r2_zs : r2_s;
        if (r2_sum[27]) begin
            nn = {r2_sum[27:2], r2_sum[1] | r2_sum[0]};
            ne = {2'd0, r2_e} + 10'd1;
        end else begin
            nn = r2_sum[26:0] << sh;
            ne = {2'd0, r2_e} - {5'd0, sh};
        end
    end

    logic        r3_spec;
    t_f32        r3_specv;
    logic        r3_s;
    logic [9:0]  r3_e;
    logic [26:0] r3_n;
    t_f32        r4_res;

    assign o_done = r_vld[3];
    assign o_res  = r4_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_spec  <= spec;
        r1_specv <= specv;
        r1_s     <= x[31];
        r1_sub   <= i_a[31] ^ i_b[31];
        r1_zs    <= (i_a[31] == i_b[31]) ? i_a[31] : 1'b0;
        r1_e     <= ex;
        r1_ma    <= {(x[30:23] != 8'd0), x[22:0], 3'd0};
        r1_mb    <= {t[49:24], |t[23:0]};

        r2_spec  <= r1_spec;
        r2_specv <= r1_specv;
        r2_s     <= r1_s;
        r2_zs    <= r1_zs;
        r2_e     <= r1_e;
        r2_sum   <= r1_sub ? ({1'b0, r1_ma} - {1'b0, r1_mb})
                           : ({1'b0, r1_ma} + {1'b0, r1_mb});

        r3_spec  <= r2_spec;
        r3_specv <= r2_specv;
        r3_s     <= ns;
        r3_e     <= ne;
        r3_n     <= nn;

        r4_res   <= r3_spec ? r3_specv : f_round(r3_s, r3_e, r3_n);
    end

endmodule

### hdl/mbbn_frcp.sv
// ----------------------------------------------------------------------------
// mbbn_frcp
// single precision reciprocal by restoring division, one bit a cycle
// ----------------------------------------------------------------------------
module mbbn_frcp
    import mbbn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_f32 i_g,
    output logic o_done,
    output t_f32 o_res
);

    typedef enum logic [1:0] {R_IDLE, R_NORM, R_DIV, R_FIN} t_rstate;

    t_rstate            r_state;
    logic               r_done;
    t_f32               r_res;
    logic               r_s;
    logic [23:0]        r_d;
    logic signed [9:0]  r_e;
    logic [25:0]        r_rem;
    logic [26:0]        r_q;
    logic [4:0]         r_cnt;

    logic               st;
    logic [26:0]        n0;
    logic [26:0]        n1;
    logic signed [10:0] b;
    logic [9:0]         be;

    always_comb begin
        st = (r_rem != 26'd0);
        if (r_q[26]) begin
            n0 = {r_q[26:1], r_q[0] | st};
            b  = 11'sd254 - 11'(r_e);
        end else begin
            n0 = {r_q[25:0], st};
            b  = 11'sd253 - 11'(r_e);
        end
        if (b == 11'sd0) begin
            n1 = {1'b0, n0[26:2], n0[1] | n0[0]};
            be = 10'd1;
        end else if (b < 11'sd0) begin
            n1 = {2'b0, n0[26:3], |n0[2:0]};
            be = 10'd1;
        end else begin
            n1 = n0;
            be = b[9:0];
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                R_IDLE: begin
                    if (i_start) begin
                        r_s   <= i_g[31];
                        r_d   <= {(i_g[30:23] != 8'd0), i_g[22:0]};
                        r_e   <= (i_g[30:23] == 8'd0) ? 10'sd1 : $signed({2'b0, i_g[30:23]});
                        r_rem <= 26'h080_0000;
                        r_cnt <= '0;
                        if (f_is_nan(i_g)) begin
                            r_res  <= CANON_NAN;
                            r_done <= 1'b1;
                        end else if (i_g[30:23] == EXP_MAX) begin
                            r_res  <= {i_g[31], 31'd0};
                            r_done <= 1'b1;
                        end else if (i_g[30:0] == 31'd0) begin
                            r_res  <= {i_g[31], EXP_MAX, 23'd0};
                            r_done <= 1'b1;
                        end else begin
                            r_state <= R_NORM;
                        end
                    end
                end
                R_NORM: begin
                    if (r_d[23]) begin
                        r_state <= R_DIV;
                    end else begin
                        r_d <= {r_d[22:0], 1'b0};
                        r_e <= r_e - 10'sd1;
                    end
                end
                R_DIV: begin
                    if (r_rem >= {2'b0, r_d}) begin
                        r_q   <= {r_q[25:0], 1'b1};
                        r_rem <= {r_rem[24:0] - {1'b0, r_d}, 1'b0};
                    end else begin
                        r_q   <= {r_q[25:0], 1'b0};
                        r_rem <= {r_rem[24:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd26) begin
                        r_state <= R_FIN;
                    end
                end
                R_FIN: begin
                    r_res   <= f_round(r_s, be, n1);
                    r_done  <= 1'b1;
                    r_state <= R_IDLE;
                end
                default: r_state <= R_IDLE;
            endcase
        end
    end

endmodule

### hdl/mbbn_back.sv
// ----------------------------------------------------------------------------
// mbbn_back
// turns a finished box into scale and centring shifts, holds the result
// ----------------------------------------------------------------------------
module mbbn_back
    import mbbn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_box             i_q_box,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [RES_W-1:0] o_data
);

    typedef enum logic [2:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_GMAX, ST_RCP, ST_DONE} t_state;

    t_state     r_state;
    t_box       r_box;
    t_f32       r_ext [3];
    t_f32       r_sum [3];
    t_f32       r_g;
    logic [2:0] r_k;
    logic       r_rcp_ok;
    t_f32       r_rcp;
    logic       r_vld;
    logic [RES_W-1:0] r_out;

    t_f32       lo [3];
    t_f32       hi [3];
    logic [2:0] km3;
    logic [1:0] ki;
    t_f32       op_a;
    t_f32       op_b;
    t_f32       g;
    logic       add_start;
    logic       add_done;
    t_f32       add_res;
    logic       rcp_start;
    logic       rcp_done;
    t_f32       rcp_res;

    assign lo[0] = r_box.lo_x;
    assign lo[1] = r_box.lo_y;
    assign lo[2] = r_box.lo_z;
    assign hi[0] = r_box.hi_x;
    assign hi[1] = r_box.hi_y;
    assign hi[2] = r_box.hi_z;

    assign km3 = r_k - 3'd3;
    assign ki  = (r_k < 3'd3) ? r_k[1:0] : km3[1:0];

    // extent = hi - lo, then sum = extent/2 + lo
    always_comb begin
        if (r_k < 3'd3) begin
            op_a = hi[ki];
            op_b = {~lo[ki][31], lo[ki][30:0]};
        end else begin
            op_a = f_half(r_ext[ki]);
            op_b = lo[ki];
        end
        g = 32'd0;
        for (int i = 0; i < 3; i++) begin
            if (!f_lt(r_ext[i], g)) begin
                g = r_ext[i];
            end
        end
    end

    assign add_start = (r_state == ST_ISSUE);
    assign rcp_start = (r_state == ST_RCP);
    assign o_q_pop   = (r_state == ST_IDLE) && i_q_valid && !r_vld;
    assign o_valid   = r_vld;
    assign o_data    = r_out;

    mbbn_fadd u_fadd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (add_start),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (add_done),
        .o_res   (add_res)
    );

    mbbn_frcp u_frcp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rcp_start),
        .i_g     (r_g),
        .o_done  (rcp_done),
        .o_res   (rcp_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_vld    <= 1'b0;
            r_rcp_ok <= 1'b0;
            r_k      <= '0;
        end else begin
            if (rcp_done) begin
                r_rcp_ok <= 1'b1;
                r_rcp    <= rcp_res;
            end
            if (r_vld && i_ready) begin
                r_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        r_box    <= i_q_box;
                        r_k      <= '0;
                        r_rcp_ok <= 1'b0;
                        r_state  <= ST_ISSUE;
                    end
                end
                ST_ISSUE: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (add_done) begin
                        if (r_k < 3'd3) begin
                            r_ext[ki] <= add_res;
                        end else begin
                            r_sum[ki] <= add_res;
                        end
                        r_k <= r_k + 3'd1;
                        if (r_k == 3'd2) begin
                            r_state <= ST_GMAX;
                        end else if (r_k == 3'd5) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                ST_GMAX: begin
                    r_g     <= g;
                    r_state <= ST_RCP;
                end
                ST_RCP: r_state <= ST_ISSUE;
                ST_DONE: begin
                    if (r_rcp_ok) begin
                        r_out <= {f_canon({~r_sum[2][31], r_sum[2][30:0]}),
                                  f_canon({~r_sum[1][31], r_sum[1][30:0]}),
                                  f_canon({~r_sum[0][31], r_sum[0][30:0]}),
                                  f_canon(r_rcp),
                                  r_box};
                        r_vld   <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### bench/mesh_bounding_box_normalizer_check.sv
// ----------------------------------------------------------------------------
// mesh_bounding_box_normalizer_check
// watches both streams, predicts the box result of every mesh and compares
// ----------------------------------------------------------------------------
module mesh_bounding_box_normalizer_check
    import mbbn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [TRI_W-1:0] i_s_tdata,
    input  logic             i_s_tlast,
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [RES_W-1:0] i_m_tdata,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_boxes_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    t_f32             box_lo [3];
    t_f32             box_hi [3];
    logic             new_mesh;
    logic [RES_W-1:0] boxes_due [$];

    function automatic logic is_nan(input t_f32 x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 0);
    endfunction

    function automatic logic is_inf(input t_f32 x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 0);
    endfunction

    function automatic real to_real(input t_f32 x);
        logic [63:0] d;
        logic [22:0] m;
        int          sh;
        m  = x[22:0];
        sh = 0;
        if (x[30:23] == 8'hFF) begin
            d = {x[31], 11'h7FF, m, 29'd0};
        end else if (x[30:0] == 0) begin
            d = {x[31], 63'd0};
        end else if (x[30:23] == 0) begin
            // subnormal: normalise so the leading one becomes the hidden bit
            while (!m[22]) begin
                m  = m << 1;
                sh++;
            end
            d = {x[31], 11'(896 - sh), m[21:0], 30'd0};
        end else begin
            d = {x[31], 11'(int'(x[30:23]) + 896), m, 29'd0};
        end
        return $bitstoreal(d);
    endfunction

    // double result rounded once more to single, nearest even
    function automatic t_f32 to_f32(input real r);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] keep;
        logic [63:0] rest;
        logic [63:0] half;
        logic [31:0] mag;
        int          ex;
        int          sh;
        d  = $realtobits(r);
        ex = int'(d[62:52]) - 1023;
        if (d[62:52] == 11'h7FF) begin
            return (d[51:0] != 0) ? CANON_NAN : {d[63], 8'hFF, 23'd0};
        end
        if (d[62:52] == 0) begin
            return {d[63], 31'd0};
        end
        sig = {11'd0, 1'b1, d[51:0]};
        sh  = (ex < -126) ? 29 - 126 - ex : 29;
        if (sh > 62) begin
            sh = 62;
        end
        keep = sig >> sh;
        rest = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rest > half || (rest == half && keep[0])) begin
            keep++;
        end
        if (ex > 127) begin
            mag = 32'h7F80_0000;
        end else if (ex >= -126) begin
            mag = 32'((ex + 126) * 8388608) + keep[31:0];
        end else begin
            mag = keep[31:0];
        end
        if (mag >= 32'h7F80_0000) begin
            mag = 32'h7F80_0000;
        end
        return {d[63], mag[30:0]};
    endfunction

    function automatic logic less_than(input t_f32 a, input t_f32 b);
        if (is_nan(a) || is_nan(b)) begin
            return 1'b0;
        end
        return to_real(a) < to_real(b);
    endfunction

    function automatic t_f32 sum_f32(input t_f32 a, input t_f32 b);
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && a[31] != b[31])) begin
            return CANON_NAN;
        end
        return to_f32(to_real(a) + to_real(b));
    endfunction

    function automatic t_f32 diff_f32(input t_f32 a, input t_f32 b);
        return sum_f32(a, is_nan(b) ? b : {~b[31], b[30:0]});
    endfunction

    function automatic t_f32 recip_f32(input t_f32 a);
        if (is_nan(a)) begin
            return CANON_NAN;
        end else if (a[30:0] == 0) begin
            return {a[31], 8'hFF, 23'd0};
        end else if (is_inf(a)) begin
            return {a[31], 31'd0};
        end
        return to_f32(1.0 / to_real(a));
    endfunction

    // result of one finished mesh, lo_x in the lowest bits
    function automatic logic [RES_W-1:0] box_result();
        logic [RES_W-1:0] r;
        t_f32             ext;
        t_f32             widest;
        t_f32             ctr;
        widest = 32'd0;
        for (int k = 0; k < 3; k++) begin
            ext = diff_f32(box_hi[k], box_lo[k]);
            if (!less_than(ext, widest)) begin
                widest = ext;
            end
            ctr = is_nan(ext) ? CANON_NAN : to_f32(to_real(ext) / 2.0);
            ctr = sum_f32(ctr, box_lo[k]);
            r[k*32 +: 32]       = box_lo[k];
            r[(k+3)*32 +: 32]   = box_hi[k];
            r[(k+7)*32 +: 32]   = is_nan(ctr) ? CANON_NAN : {~ctr[31], ctr[30:0]};
        end
        r[6*32 +: 32] = recip_f32(widest);
        return r;
    endfunction

    string field_name [10] = '{"lo_x", "lo_y", "lo_z", "hi_x", "hi_y", "hi_z",
                               "unit_scale", "shift_x", "shift_y", "shift_z"};

    always @(posedge i_clk) begin
        logic [RES_W-1:0] due;
        t_f32             v;
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                box_lo[k] = 32'd0;
                box_hi[k] = 32'd0;
            end
            new_mesh = 1'b1;
            boxes_due.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
            o_boxes_seen <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_boxes_seen <= o_boxes_seen + 1;
                if (boxes_due.size() == 0) begin
                    $error("box result with none outstanding: %h", i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    due = boxes_due.pop_front();
                    if (due !== i_m_tdata) begin
                        o_fail_count <= o_fail_count + 1;
                    end
                    for (int f = 0; f < 10; f++) begin
                        if (due[f*32 +: 32] !== i_m_tdata[f*32 +: 32]) begin
                            $error("%s: expected %h, actual %h", field_name[f],
                                   due[f*32 +: 32], i_m_tdata[f*32 +: 32]);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (new_mesh) begin
                    for (int k = 0; k < 3; k++) begin
                        box_lo[k] = i_s_tdata[k*32 +: 32];
                        box_hi[k] = i_s_tdata[k*32 +: 32];
                    end
                    new_mesh = 1'b0;
                end
                // vertices a, b, c in order; the later of equal values wins
                for (int n = 0; n < 3; n++) begin
                    for (int k = 0; k < 3; k++) begin
                        v = i_s_tdata[(n*3+k)*32 +: 32];
                        if (!less_than(box_lo[k], v)) box_lo[k] = v;
                        if (!less_than(v, box_hi[k])) box_hi[k] = v;
                    end
                end
                if (i_s_tlast) begin
                    boxes_due = {boxes_due, box_result()};
                    new_mesh = 1'b1;
                end
            end
            o_pending <= boxes_due.size();
        end
    end

endmodule

### bench/mesh_bounding_box_normalizer_test.sv
// ----------------------------------------------------------------------------
// mesh_bounding_box_normalizer_test
// streams triangle meshes into the normaliser with random gaps and stalls;
// the checker predicts every box result and counts mismatches
// ----------------------------------------------------------------------------
module mesh_bounding_box_normalizer_test
    import mbbn_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [TRI_W-1:0] s_axis_tdata;   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    logic             s_axis_tlast;   // final_tri
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [RES_W-1:0] m_axis_tdata;   // lo_x .. hi_z, unit_scale, shift_x .. shift_z

    int fail_count;
    int boxes_pending;
    int boxes_seen;
    int tris_sent;
    int meshes_sent;
    logic sender_steady;   // no gaps while set
    logic sink_steady;

    mesh_bounding_box_normalizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mesh_bounding_box_normalizer_check checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (boxes_pending),
        .o_boxes_seen (boxes_seen)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // guard against a hung handshake; far beyond the slowest legal run
    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    // one coordinate; tame ones mostly, full random bits and specials otherwise
    function automatic t_f32 pick_coord(input logic tame);
        int   kind;
        t_f32 spec [8] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                           32'h0000_0001, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0080_0000};
        kind = tame ? $urandom_range(0, 79) : $urandom_range(0, 99);
        if (kind < 55) begin
            return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
        end else if (kind < 68) begin
            return {1'($urandom), 8'($urandom_range(1, 254)), 23'($urandom)};
        end else if (kind < 75) begin
            return spec[$urandom_range(0, 7)];
        end else if (kind < 80) begin
            return {1'($urandom), 8'd0, 23'($urandom)};   // subnormal
        end else if (kind < 88) begin
            return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
        end
        return $urandom;
    endfunction

    // one triangle transaction, gap drawn before it
    task automatic send_tri(input t_f32 v [9], input logic last);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        for (int k = 0; k < 9; k++) begin
            s_axis_tdata[k*32 +: 32] <= v[k];
        end
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        tris_sent++;
        if (last) meshes_sent++;
    endtask

    // single triangle mesh of one repeated value
    task automatic send_flat(input t_f32 x);
        t_f32 v [9];
        foreach (v[k]) v[k] = x;
        send_tri(v, 1'b1);
    endtask

    // result side: a fresh random stall before each box result, none while sink_steady is set
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        sink_steady   = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 7) == 0) sink_steady = ~sink_steady;
            gap = sink_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        t_f32 v [9];
        int   mesh_len;
        logic tame;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        sender_steady = 1'b0;
        tris_sent     = 0;
        meshes_sent   = 0;
        i_rst_n       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero extent with either zero, huge and infinite spans,
        // nan vertices, subnormals and an all-ones pattern
        send_flat(32'h0000_0000);
        send_flat(32'h8000_0000);
        send_flat(32'h3F80_0000);
        v = '{32'h7F7F_FFFF, 32'h0000_0001, 32'h8000_0000, 32'hFF7F_FFFF, 32'h0000_0000,
              32'h0000_0000, 32'h0000_0000, 32'h8000_0001, 32'h8000_0000};
        send_tri(v, 1'b1);
        v = '{32'h7F80_0000, 32'h3F00_0000, 32'h4000_0000, 32'hFF80_0000, 32'hBF00_0000,
              32'h7F80_0000, 32'h0000_0000, 32'h0000_0000, 32'h7F80_0000};
        send_tri(v, 1'b1);
        v = '{32'h3F80_0000, 32'h7FC0_0000, 32'h4040_0000, 32'h7FFF_FFFF, 32'h4000_0000,
              32'h4040_0000, 32'h4000_0000, 32'hC000_0000, 32'hFFC0_0001};
        send_tri(v, 1'b0);
        v = '{32'h4100_0000, 32'h3F80_0000, 32'h0000_0000, 32'hC100_0000, 32'h3F80_0000,
              32'h8000_0000, 32'h3E80_0000, 32'h3F80_0000, 32'h0000_0000};
        send_tri(v, 1'b1);
        v = '{32'h007F_FFFF, 32'h8000_0001, 32'h0000_0003, 32'h0000_0001, 32'h807F_FFFF,
              32'h0000_0002, 32'h0080_0000, 32'h0000_0000, 32'h0000_0001};
        send_tri(v, 1'b1);
        send_flat(32'hFFFF_FFFF);
        for (int t = 0; t < 4; t++) begin
            foreach (v[k]) v[k] = pick_coord(1'b1);
            send_tri(v, t == 3);
        end

        // let the block drain completely before the random part
        s_axis_tvalid <= 1'b0;
        while (boxes_pending != 0) @(negedge i_clk);

        // random meshes: mostly short and well formed, a few long or wild
        while (tris_sent < 412) begin
            mesh_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                    : $urandom_range(1, 5);
            tame = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 3) == 0) sender_steady = ~sender_steady;
            for (int t = 0; t < mesh_len; t++) begin
                foreach (v[k]) v[k] = pick_coord(tame);
                send_tri(v, t == mesh_len - 1);
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain until every predicted box result has been returned, then let the clock run on
        while (boxes_pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        $display("run covered %0d triangles in %0d meshes, %0d box results returned",
                 tris_sent, meshes_sent, boxes_seen);
        $display("including signed zeros, infinities, nan and subnormal coordinates");
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/mbbn_pkg.sv
hdl/mbbn_fifo.sv
hdl/mbbn_front.sv
hdl/mbbn_fadd.sv
hdl/mbbn_frcp.sv
hdl/mbbn_back.sv
hdl/mesh_bounding_box_normalizer.sv
bench/mesh_bounding_box_normalizer_check.sv
bench/mesh_bounding_box_normalizer_test.sv
